[rtl/gpshc_pkg.sv]
// Package for the GPS heading world calibration block: payload structs,
// register indexes, angle constants and the angle wrap helpers.
// No dependencies.
`default_nettype none

package gpshc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] RegMaxSpeed    = 3'd0;
  localparam logic [2:0] RegMinSpeed    = 3'd1;
  localparam logic [2:0] RegCalMinSpeed = 3'd2;
  localparam logic [2:0] RegCalMaxDev   = 3'd3;
  localparam logic [2:0] RegCalTarget   = 3'd4;
  localparam logic [2:0] RegCalGoodStep = 3'd5;
  localparam logic [2:0] RegCalPenalty  = 3'd6;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  // Register reset values.
  localparam logic [13:0] MaxSpeedRst    = 14'd1000;
  localparam logic [13:0] MinSpeedRst    = 14'd30;
  localparam logic [13:0] CalMinSpeedRst = 14'd200;
  localparam logic [14:0] CalMaxDevRst   = 15'd300;
  localparam logic [15:0] CalTargetRst   = 16'd5000;
  localparam logic [15:0] CalGoodStepRst = 16'd100;
  localparam logic [15:0] CalPenaltyRst  = 16'd200;

  // Heading source codes.
  localparam logic [1:0] SrcNone  = 2'd0;
  localparam logic [1:0] SrcBoat  = 2'd1;
  localparam logic [1:0] SrcMotor = 2'd2;

  localparam logic [6:0] PctFull = 7'd100;

  localparam logic [15:0]        FullTurn   = 16'd36000;
  localparam logic signed [16:0] HalfPos17  = 17'sd18000;
  localparam logic signed [16:0] HalfNeg17  = -17'sd18000;
  localparam logic signed [16:0] FullTurn17 = 17'sd36000;
  localparam logic signed [17:0] FullTurn18 = 18'sd36000;

  typedef struct packed {
    logic        speed_valid;
    logic        course_valid;
    logic        fix_updated;
    logic [15:0] speed_cms;
    logic [15:0] course_cdeg;
    logic        motor_imu_valid;
    logic [15:0] motor_raw_cdeg;
    logic        boat_imu_valid;
    logic [15:0] boat_raw_cdeg;
  } gpshc_in_t;

  typedef struct packed {
    logic [6:0]         speed_pct;
    logic [15:0]        heading_cdeg;
    logic               heading_ok;
    logic [1:0]         heading_source;
    logic [15:0]        motor_shown_cdeg;
    logic [15:0]        boat_world_cdeg;
    logic signed [15:0] motor_angle_cdeg;
    logic               calibrated;
    logic [15:0]        stability_score;
  } gpshc_out_t;

  // Reduce a 16-bit angle into 0..35999 with one conditional subtract.
  function automatic logic [15:0] reduce_turn(logic [15:0] x);
    return (x >= FullTurn) ? (x - FullTurn) : x;
  endfunction

  // Difference of two reduced angles, wrapped into -18000..17999.
  function automatic logic signed [15:0] wrap_half(logic [15:0] a, logic [15:0] b);
    logic signed [16:0] d;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    if (d >= HalfPos17) begin
      return 16'(d - FullTurn17);
    end else if (d < HalfNeg17) begin
      return 16'(d + FullTurn17);
    end
    return 16'(d);
  endfunction

  // Reduced angle plus a half-wrapped offset, back into 0..35999.
  function automatic logic [15:0] wrap_full(logic [15:0] a, logic signed [15:0] off);
    logic signed [17:0] s;
    s = $signed({2'b00, a}) + $signed({{2{off[15]}}, off});
    if (s < 18'sd0) begin
      return 16'(s + FullTurn18);
    end else if (s >= FullTurn18) begin
      return 16'(s - FullTurn18);
    end
    return 16'(s);
  endfunction

endpackage

`default_nettype wire

[rtl/gps_heading_world_calibration.sv]
// GPS heading world calibration: top level with register file, sequencer,
// shared restoring divide step and calibration state. Uses gpshc_pkg.
`default_nettype none

// One update is taken when in_ready_o is high and is processed in order:
// StPrep reduces the angles and forms speed*100, then the shared
// compare-subtract unit runs one quotient bit per cycle (a first step that
// detects a quotient of 128 or more ends the division early, otherwise seven
// more steps follow), then StDev forms the course deviation, StScore does
// the score and offset update and StAng the motor angle. The result lands
// in an output register, so the next update can be accepted while it
// waits; the block stalls only in StAng when that register is still full.
// Configuration is written through cfg_we_i with no wait and is used by
// every later step, including those of an update in progress.
module gps_heading_world_calibration (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire gpshc_pkg::gpshc_in_t                 in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output gpshc_pkg::gpshc_out_t                     out_data_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [gpshc_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire logic [gpshc_pkg::CfgDataWidth-1:0]   cfg_wdata_i
);
  import gpshc_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPrep  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StDev   = 3'd3;
  localparam logic [2:0] StScore = 3'd4;
  localparam logic [2:0] StAng   = 3'd5;

  // Configuration registers.
  logic [13:0] max_speed_q, min_speed_q, cal_min_speed_q;
  logic [14:0] cal_max_dev_q;
  logic [15:0] cal_target_q, cal_good_q, cal_penalty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q     <= MaxSpeedRst;
      min_speed_q     <= MinSpeedRst;
      cal_min_speed_q <= CalMinSpeedRst;
      cal_max_dev_q   <= CalMaxDevRst;
      cal_target_q    <= CalTargetRst;
      cal_good_q      <= CalGoodStepRst;
      cal_penalty_q   <= CalPenaltyRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaxSpeed:    max_speed_q     <= cfg_wdata_i[13:0];
        RegMinSpeed:    min_speed_q     <= cfg_wdata_i[13:0];
        RegCalMinSpeed: cal_min_speed_q <= cfg_wdata_i[13:0];
        RegCalMaxDev:   cal_max_dev_q   <= cfg_wdata_i[14:0];
        RegCalTarget:   cal_target_q    <= cfg_wdata_i;
        RegCalGoodStep: cal_good_q      <= cfg_wdata_i;
        RegCalPenalty:  cal_penalty_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer and working registers.
  logic [2:0]  state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  gpshc_in_t   in_q;
  logic [15:0] course_q, course_d, mraw_q, mraw_d, braw_q, braw_d;
  logic        spd_zero_q, spd_zero_d;
  logic [22:0] rem_q, rem_d;
  logic [6:0]  quot_q, quot_d;
  logic [6:0]  pct_q, pct_d;
  logic signed [15:0] dev_q, dev_d, moff_c_q, moff_c_d, boff_c_q, boff_c_d;
  logic [15:0] mworld_c_q, mworld_c_d, bworld_c_q, bworld_c_d;

  // Calibration state.
  logic        cal_running_q, cal_running_d;
  logic [15:0] ref_q, ref_d;
  logic [15:0] score_q, score_d;
  logic        latched_q, latched_d;
  logic signed [15:0] moff_q, moff_d, boff_q, boff_d;
  logic [15:0] mworld_q, mworld_d, bworld_q, bworld_d, mdisp_q, mdisp_d;

  gpshc_out_t  out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic        in_fire;
  logic        out_free;

  // Datapath temporaries.
  logic [15:0] spd_eff;
  logic [22:0] dvs_shift;
  logic        rem_ge;
  logic [15:0] dev_abs;
  logic [16:0] good_sum;
  logic [15:0] score_new;
  logic        pass;
  logic        cal_speed_ok;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Shared compare-subtract unit of the divider.
  assign dvs_shift = {9'd0, max_speed_q} << cnt_q;
  assign rem_ge    = (rem_q >= dvs_shift);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    course_d      = course_q;
    mraw_d        = mraw_q;
    braw_d        = braw_q;
    spd_zero_d    = spd_zero_q;
    rem_d         = rem_q;
    quot_d        = quot_q;
    pct_d         = pct_q;
    dev_d         = dev_q;
    moff_c_d      = moff_c_q;
    boff_c_d      = boff_c_q;
    mworld_c_d    = mworld_c_q;
    bworld_c_d    = bworld_c_q;
    cal_running_d = cal_running_q;
    ref_d         = ref_q;
    score_d       = score_q;
    latched_d     = latched_q;
    moff_d        = moff_q;
    boff_d        = boff_q;
    mworld_d      = mworld_q;
    bworld_d      = bworld_q;
    mdisp_d       = mdisp_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ready_i;

    spd_eff      = in_q.speed_valid ? in_q.speed_cms : 16'd0;
    if (spd_eff < {2'b00, min_speed_q}) begin
      spd_eff = 16'd0;
    end
    dev_abs      = dev_q[15] ? 16'(-dev_q) : 16'(dev_q);
    good_sum     = {1'b0, score_q} + {1'b0, cal_good_q};
    score_new    = score_q;
    pass         = 1'b0;
    cal_speed_ok = in_q.speed_valid && in_q.course_valid &&
                   (in_q.speed_cms >= {2'b00, cal_min_speed_q});

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        course_d   = reduce_turn(in_q.course_cdeg);
        mraw_d     = reduce_turn(in_q.motor_raw_cdeg);
        braw_d     = reduce_turn(in_q.boat_raw_cdeg);
        spd_zero_d = (spd_eff == 16'd0);
        // speed * 100 as shifts and adds.
        rem_d      = ({7'd0, spd_eff} << 6) + ({7'd0, spd_eff} << 5) +
                     ({7'd0, spd_eff} << 2);
        quot_d     = 7'd0;
        cnt_d      = 3'd7;
        state_d    = StDiv;
      end
      StDiv: begin
        if (cnt_q == 3'd7) begin
          // A quotient of 128 or more, or a zero maximum, saturates.
          if (rem_ge) begin
            pct_d   = spd_zero_q ? 7'd0 : PctFull;
            state_d = StDev;
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end else begin
          if (rem_ge) begin
            rem_d         = rem_q - dvs_shift;
            quot_d[cnt_q] = 1'b1;
          end
          if (cnt_q == 3'd0) begin
            pct_d   = (quot_d > PctFull) ? PctFull : quot_d;
            state_d = StDev;
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
      end
      StDev: begin
        dev_d      = wrap_half(course_q, ref_q);
        moff_c_d   = wrap_half(course_q, mraw_q);
        boff_c_d   = wrap_half(course_q, braw_q);
        mworld_c_d = wrap_full(mraw_q, moff_q);
        bworld_c_d = wrap_full(braw_q, boff_q);
        state_d    = StScore;
      end
      StScore: begin
        if (in_q.motor_imu_valid) begin
          if (latched_q) begin
            mworld_d = mworld_c_q;
            mdisp_d  = mworld_c_q;
          end else begin
            mdisp_d = mraw_q;
          end
        end
        if (in_q.boat_imu_valid && latched_q) begin
          bworld_d = bworld_c_q;
        end
        if (!latched_q) begin
          if (!cal_speed_ok) begin
            cal_running_d = 1'b0;
            score_d       = 16'd0;
          end else if (!cal_running_q) begin
            cal_running_d = 1'b1;
            ref_d         = course_q;
            score_d       = 16'd0;
          end else begin
            if (in_q.fix_updated) begin
              if (dev_abs <= {1'b0, cal_max_dev_q}) begin
                score_new = (good_sum > {1'b0, cal_target_q}) ? cal_target_q
                                                              : good_sum[15:0];
              end else begin
                score_new = (score_q > cal_penalty_q) ? (score_q - cal_penalty_q)
                                                      : 16'd0;
                ref_d     = course_q;
              end
            end
            score_d = score_new;
            pass    = (score_new >= cal_target_q);
          end
          // Both world headings equal the course at the moment of latching.
          if (pass && in_q.motor_imu_valid && in_q.boat_imu_valid) begin
            moff_d    = moff_c_q;
            boff_d    = boff_c_q;
            mworld_d  = course_q;
            bworld_d  = course_q;
            latched_d = 1'b1;
          end
        end
        state_d = StAng;
      end
      StAng: begin
        if (out_free) begin
          out_d.speed_pct        = pct_q;
          out_d.heading_cdeg     = latched_q ? bworld_q : 16'd0;
          out_d.heading_ok       = latched_q;
          out_d.heading_source   = latched_q ? SrcBoat : SrcNone;
          out_d.motor_shown_cdeg = mdisp_q;
          out_d.boat_world_cdeg  = bworld_q;
          out_d.motor_angle_cdeg = latched_q ? wrap_half(bworld_q, mworld_q)
                                             : 16'sd0;
          out_d.calibrated       = latched_q;
          out_d.stability_score  = score_q;
          out_valid_d            = 1'b1;
          state_d                = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      out_valid_q   <= 1'b0;
      cal_running_q <= 1'b0;
      ref_q         <= 16'd0;
      score_q       <= 16'd0;
      latched_q     <= 1'b0;
      moff_q        <= 16'sd0;
      boff_q        <= 16'sd0;
      mworld_q      <= 16'd0;
      bworld_q      <= 16'd0;
      mdisp_q       <= 16'd0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      cal_running_q <= cal_running_d;
      ref_q         <= ref_d;
      score_q       <= score_d;
      latched_q     <= latched_d;
      moff_q        <= moff_d;
      boff_q        <= boff_d;
      mworld_q      <= mworld_d;
      bworld_q      <= bworld_d;
      mdisp_q       <= mdisp_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    cnt_q      <= cnt_d;
    course_q   <= course_d;
    mraw_q     <= mraw_d;
    braw_q     <= braw_d;
    spd_zero_q <= spd_zero_d;
    rem_q      <= rem_d;
    quot_q     <= quot_d;
    pct_q      <= pct_d;
    dev_q      <= dev_d;
    moff_c_q   <= moff_c_d;
    boff_c_q   <= boff_c_d;
    mworld_c_q <= mworld_c_d;
    bworld_c_q <= bworld_c_d;
    out_q      <= out_d;
  end

  // Once the offsets are latched they and the score never change again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    latched_q |=> latched_q && $stable(score_q) && $stable(moff_q) && $stable(boff_q))
    else $error("calibration state changed after latching");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.speed_pct <= PctFull)
    else $error("speed percent above full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.heading_ok == out_data_o.calibrated) &&
      (out_data_o.heading_source == (out_data_o.calibrated ? SrcBoat : SrcNone)))
    else $error("heading flags disagree with calibration status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.boat_world_cdeg < FullTurn) &&
      (out_data_o.motor_shown_cdeg < FullTurn))
    else $error("heading out of the turn range");

  // A new transaction is taken only when the sequencer has finished the last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == StPrep)
    else $error("accepted transaction did not start processing");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for gps_heading_world_calibration: a directed table
// followed by random fusion updates, checked against an in-bench predictor or, for some directed rows, fixed reports.
// Depends on gpshc_pkg and the RTL top level only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpshc_pkg::*;

  localparam int TurnCdeg   = 36000;
  localparam int HalfCdeg   = 18000;
  localparam int StallLimit = 4000;
  localparam int HoldCycles = 400;

  typedef struct {
    logic [13:0] max_speed;
    logic [13:0] min_speed;
    logic [13:0] cal_min_speed;
    logic [14:0] max_dev;
    logic [15:0] target;
    logic [15:0] step;
    logic [15:0] penalty;
  } cal_cfg_t;

  typedef struct {
    bit                 running;
    logic [15:0]        ref_course;
    logic [15:0]        score;
    bit                 latched;
    logic signed [15:0] motor_off;
    logic signed [15:0] boat_off;
    logic [15:0]        motor_world;
    logic [15:0]        boat_world;
    logic [15:0]        motor_disp;
  } heading_state_t;

  typedef enum logic {RowUpdate, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [2:0] reg_idx;
    logic [15:0] reg_val;
    gpshc_in_t  upd;
    bit         typed;
    logic [6:0] pct;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  gpshc_in_t   in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  gpshc_out_t  out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i = RegMaxSpeed;
  logic [CfgDataWidth-1:0] cfg_wdata_i = '0;

  cal_cfg_t       cal_cfg;
  heading_state_t cal_st;
  gpshc_out_t     fused_q[$];
  dir_row_t       dir_tab[$];
  int             items_in = 0;
  int             results_seen = 0;
  int             faults = 0;
  int             track_cdeg = 0;
  bit             held_off = 1'b0;
  logic           no_gaps;

  // Neither side inserts random gaps while this window of transactions goes through.
  assign no_gaps = (items_in >= 600) && (items_in < 800);

  gps_heading_world_calibration DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int turn_mod(int d);
    int m;
    m = d % TurnCdeg;
    if (m < 0) m += TurnCdeg;
    return m;
  endfunction

  function automatic int turn_half(int d);
    int m;
    m = turn_mod(d);
    if (m >= HalfCdeg) m -= TurnCdeg;
    return m;
  endfunction

  // Predicts the report of one update and advances the calibration state.
  function automatic gpshc_out_t fuse_update(gpshc_in_t it, cal_cfg_t c,
                                             inout heading_state_t s);
    int spd, crs, mraw, braw, pct, dev, sum, ang;
    bit pass;
    gpshc_out_t o;
    spd  = it.speed_valid ? int'(it.speed_cms) : 0;
    crs  = int'(it.course_cdeg) % TurnCdeg;
    mraw = int'(it.motor_raw_cdeg) % TurnCdeg;
    braw = int'(it.boat_raw_cdeg) % TurnCdeg;
    if (spd < int'(c.min_speed)) spd = 0;
    if (c.max_speed == 0) begin
      pct = (spd != 0) ? 100 : 0;
    end else begin
      pct = (spd * 100) / int'(c.max_speed);
      if (pct > 100) pct = 100;
    end
    if (it.motor_imu_valid) begin
      if (s.latched) begin
        s.motor_world = 16'(turn_mod(mraw + int'(s.motor_off)));
        s.motor_disp  = s.motor_world;
      end else begin
        s.motor_disp = 16'(mraw);
      end
    end
    if (it.boat_imu_valid && s.latched) begin
      s.boat_world = 16'(turn_mod(braw + int'(s.boat_off)));
    end
    if (!s.latched) begin
      pass = 1'b0;
      if (!it.speed_valid || !it.course_valid || it.speed_cms < c.cal_min_speed) begin
        s.running = 1'b0;
        s.score   = '0;
      end else if (!s.running) begin
        s.running    = 1'b1;
        s.ref_course = 16'(crs);
        s.score      = '0;
      end else begin
        if (it.fix_updated) begin
          dev = turn_half(crs - int'(s.ref_course));
          if (dev < 0) dev = -dev;
          if (dev <= int'(c.max_dev)) begin
            sum = int'(s.score) + int'(c.step);
            if (sum > int'(c.target)) sum = int'(c.target);
            s.score = 16'(sum);
          end else begin
            s.score      = (s.score > c.penalty) ? s.score - c.penalty : 16'd0;
            s.ref_course = 16'(crs);
          end
        end
        pass = (s.score >= c.target);
      end
      if (pass && it.motor_imu_valid && it.boat_imu_valid) begin
        s.motor_off   = 16'(turn_half(crs - mraw));
        s.boat_off    = 16'(turn_half(crs - braw));
        s.motor_world = 16'(turn_mod(mraw + int'(s.motor_off)));
        s.boat_world  = 16'(turn_mod(braw + int'(s.boat_off)));
        s.latched     = 1'b1;
      end
    end
    ang = s.latched ? turn_half(int'(s.boat_world) - int'(s.motor_world)) : 0;
    o.speed_pct        = 7'(pct);
    o.heading_cdeg     = s.latched ? s.boat_world : 16'd0;
    o.heading_ok       = s.latched;
    o.heading_source   = s.latched ? SrcBoat : SrcNone;
    o.motor_shown_cdeg = s.motor_disp;
    o.boat_world_cdeg  = s.boat_world;
    o.motor_angle_cdeg = 16'(ang);
    o.calibrated       = s.latched;
    o.stability_score  = s.score;
    return o;
  endfunction

  function automatic int rand_angle();
    if ($urandom_range(0, 99) < 5) return int'($urandom_range(TurnCdeg, 65535));
    return int'($urandom_range(0, TurnCdeg - 1));
  endfunction

  // Most updates follow a steady course near track_cdeg; the rest are noise
  // or sequences broken by an invalid flag or a low speed.
  function automatic gpshc_in_t make_update();
    gpshc_in_t u;
    int roll, base, lim, off, crs, spd;
    roll = int'($urandom_range(0, 99));
    if (roll < 15) begin
      u.speed_valid     = 1'($urandom_range(0, 1));
      u.course_valid    = 1'($urandom_range(0, 1));
      u.fix_updated     = 1'($urandom_range(0, 1));
      u.speed_cms       = 16'($urandom_range(0, 65535));
      u.course_cdeg     = 16'($urandom_range(0, 65535));
      u.motor_imu_valid = 1'($urandom_range(0, 1));
      u.motor_raw_cdeg  = 16'($urandom_range(0, 65535));
      u.boat_imu_valid  = 1'($urandom_range(0, 1));
      u.boat_raw_cdeg   = 16'($urandom_range(0, 65535));
      return u;
    end
    u.speed_valid  = 1'b1;
    u.course_valid = 1'b1;
    u.fix_updated  = ($urandom_range(0, 99) < 85);
    base = int'(cal_cfg.cal_min_speed);
    if ($urandom_range(0, 1)) begin
      spd = int'($urandom_range(base, base + int'(cal_cfg.max_speed) + 200));
    end else begin
      spd = int'($urandom_range(base, 65535));
    end
    if (spd > 65535) spd = 65535;
    u.speed_cms = 16'(spd);
    if ($urandom_range(0, 99) < 10) track_cdeg = int'($urandom_range(0, TurnCdeg - 1));
    lim = (int'(cal_cfg.max_dev) < HalfCdeg) ? int'(cal_cfg.max_dev) : HalfCdeg;
    off = int'($urandom_range(0, lim));
    if ($urandom_range(0, 99) < 15) off = lim + 1 + int'($urandom_range(0, 200));
    if ($urandom_range(0, 1)) off = -off;
    crs = turn_mod(track_cdeg + off);
    if (crs < 65536 - TurnCdeg && $urandom_range(0, 99) < 5) crs += TurnCdeg;
    u.course_cdeg = 16'(crs);
    track_cdeg = turn_mod(track_cdeg + int'($urandom_range(0, 20)) - 10);
    if (roll < 25) begin
      case ($urandom_range(0, 2))
        0: u.speed_valid = 1'b0;
        1: u.course_valid = 1'b0;
        default: if (base > 0) u.speed_cms = 16'($urandom_range(0, base - 1));
      endcase
    end
    u.motor_imu_valid = ($urandom_range(0, 99) < 85);
    u.motor_raw_cdeg  = 16'(rand_angle());
    u.boat_imu_valid  = ($urandom_range(0, 99) < 85);
    u.boat_raw_cdeg   = 16'(rand_angle());
    return u;
  endfunction

  function automatic gpshc_in_t upd(bit sv, bit cv, bit fx, int spd, int crs,
                                    bit mv, int mr, bit bv, int br);
    gpshc_in_t u;
    u.speed_valid     = sv;
    u.course_valid    = cv;
    u.fix_updated     = fx;
    u.speed_cms       = 16'(spd);
    u.course_cdeg     = 16'(crs);
    u.motor_imu_valid = mv;
    u.motor_raw_cdeg  = 16'(mr);
    u.boat_imu_valid  = bv;
    u.boat_raw_cdeg   = 16'(br);
    return u;
  endfunction

  task automatic add_upd(gpshc_in_t u, bit typed = 1'b0, logic [6:0] pct = '0);
    dir_row_t r;
    r.kind    = RowUpdate;
    r.reg_idx = RegMaxSpeed;
    r.reg_val = '0;
    r.upd     = u;
    r.typed   = typed;
    r.pct     = pct;
    dir_tab.push_back(r);
  endtask

  task automatic add_reg(logic [2:0] idx, logic [15:0] val);
    dir_row_t r;
    r.kind    = RowWrite;
    r.reg_idx = idx;
    r.reg_val = val;
    r.upd     = '0;
    r.typed   = 1'b0;
    r.pct     = '0;
    dir_tab.push_back(r);
  endtask

  // Sends one update. Without may_latch, an update that would latch the
  // world offsets loses its boat reading so calibration keeps running.
  task automatic push_update(gpshc_in_t it, bit may_latch, bit typed = 1'b0,
                             gpshc_out_t typed_exp = '0);
    heading_state_t trial;
    gpshc_out_t pred;
    trial = cal_st;
    pred  = fuse_update(it, cal_cfg, trial);
    if (!may_latch && trial.latched && !cal_st.latched) begin
      it.boat_imu_valid = 1'b0;
      trial = cal_st;
      pred  = fuse_update(it, cal_cfg, trial);
    end
    while (!no_gaps && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    if (cfg_we_i) cfg_we_i <= 1'b0;
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cal_st = trial;
    items_in++;
    fused_q.push_back(typed ? typed_exp : pred);
  endtask

  // Stops offering updates and waits until every report has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (fused_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      RegMaxSpeed:    cal_cfg.max_speed     = val[13:0];
      RegMinSpeed:    cal_cfg.min_speed     = val[13:0];
      RegCalMinSpeed: cal_cfg.cal_min_speed = val[13:0];
      RegCalMaxDev:   cal_cfg.max_dev       = val[14:0];
      RegCalTarget:   cal_cfg.target        = val;
      RegCalGoodStep: cal_cfg.step          = val;
      RegCalPenalty:  cal_cfg.penalty       = val;
      default: ;
    endcase
  endtask

  task automatic set_cfg(int mx, int mn, int cmin, int dev, int tgt, int stp, int pen);
    settle();
    write_reg(RegMaxSpeed, 16'(mx));
    write_reg(RegMinSpeed, 16'(mn));
    write_reg(RegCalMinSpeed, 16'(cmin));
    write_reg(RegCalMaxDev, 16'(dev));
    write_reg(RegCalTarget, 16'(tgt));
    write_reg(RegCalGoodStep, 16'(stp));
    write_reg(RegCalPenalty, 16'(pen));
  endtask

  task automatic rand_cfg(bit full);
    if (full) begin
      set_cfg($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535));
    end else begin
      set_cfg($urandom_range(1, 10000), $urandom_range(0, 10000), $urandom_range(0, 10000),
              $urandom_range(0, 18000), $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535));
    end
  endtask

  task automatic run_updates(int n, bit may_latch);
    for (int k = 0; k < n; k++) push_update(make_update(), may_latch);
  endtask

  task automatic cmp_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      faults++;
      if (faults <= 10) begin
        $display("report %0d: %s expected %0d, got %0d", results_seen, name, want, got);
      end
    end
  endtask

  task automatic check_report(gpshc_out_t got);
    gpshc_out_t want;
    if (fused_q.size() == 0) begin
      faults++;
      if (faults <= 10) $display("report with no update outstanding: %p", got);
      return;
    end
    want = fused_q.pop_front();
    results_seen++;
    cmp_field("speed_pct", want.speed_pct, got.speed_pct);
    cmp_field("heading_cdeg", want.heading_cdeg, got.heading_cdeg);
    cmp_field("heading_ok", want.heading_ok, got.heading_ok);
    cmp_field("heading_source", want.heading_source, got.heading_source);
    cmp_field("motor_shown_cdeg", want.motor_shown_cdeg, got.motor_shown_cdeg);
    cmp_field("boat_world_cdeg", want.boat_world_cdeg, got.boat_world_cdeg);
    cmp_field("motor_angle_cdeg", want.motor_angle_cdeg, got.motor_angle_cdeg);
    cmp_field("calibrated", want.calibrated, got.calibrated);
    cmp_field("stability_score", want.stability_score, got.stability_score);
  endtask

  // Report side: random back-pressure plus one long hold-off while the
  // sender keeps offering updates.
  initial begin : report_sink
    int hold;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_report(out_data_o);
      if (!held_off && items_in >= 300) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        hold = 0;
        while (hold < HoldCycles) begin
          @(posedge clk_i);
          hold++;
        end
      end else begin
        out_ready_i <= no_gaps || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    dir_row_t r;
    gpshc_out_t typed_exp;
    cal_cfg = '{MaxSpeedRst, MinSpeedRst, CalMinSpeedRst, CalMaxDevRst,
                CalTargetRst, CalGoodStepRst, CalPenaltyRst};
    cal_st = '{default: '0};

    // Speed percent at its edges; nothing is calibrating yet.
    add_upd(upd(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 7'd0);
    add_upd(upd(1, 0, 0, 65535, 0, 0, 0, 0, 0), 1'b1, PctFull);
    add_upd(upd(0, 1, 1, 65535, 0, 0, 0, 0, 0), 1'b1, 7'd0);
    add_upd(upd(1, 0, 0, 29, 0, 0, 0, 0, 0), 1'b1, 7'd0);
    add_upd(upd(1, 0, 0, 30, 0, 0, 0, 0, 0), 1'b1, 7'd3);
    add_upd(upd(1, 0, 0, 999, 0, 0, 0, 0, 0), 1'b1, 7'd99);
    add_upd(upd(1, 0, 0, 1010, 0, 0, 0, 0, 0), 1'b1, PctFull);
    // Course scoring: start, steady at the deviation limit, one past it,
    // no new fix, out-of-range angles, low speed and invalid course.
    add_upd(upd(1, 1, 1, 500, 35999, 1, 0, 1, 35999));
    add_upd(upd(1, 1, 1, 500, 299, 1, 100, 1, 200));
    add_upd(upd(1, 1, 1, 500, 300, 0, 0, 1, 0));
    add_upd(upd(1, 1, 0, 500, 18000, 1, 35999, 0, 0));
    add_upd(upd(1, 1, 1, 65535, 36300, 1, 65535, 1, 65535));
    add_upd(upd(1, 1, 1, 199, 300, 1, 0, 1, 0));
    add_upd(upd(1, 0, 1, 500, 300, 0, 0, 0, 0));
    // A zero maximum speed gives full percent for any nonzero speed.
    add_reg(RegMaxSpeed, 16'd0);
    add_reg(RegMinSpeed, 16'd0);
    add_upd(upd(1, 0, 0, 1, 0, 0, 0, 0, 0));
    add_upd(upd(1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_upd(upd(0, 0, 0, 16383, 0, 1, 36000, 0, 0));
    add_reg(RegMaxSpeed, 16'(MaxSpeedRst));
    add_reg(RegMinSpeed, 16'(MinSpeedRst));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[n]) begin
      r = dir_tab[n];
      if (r.kind == RowWrite) begin
        settle();
        write_reg(r.reg_idx, r.reg_val);
      end else begin
        typed_exp = '0;
        typed_exp.speed_pct = r.pct;
        push_update(r.upd, 1'b0, r.typed, typed_exp);
      end
    end

    // Calibration keeps running through these settings without latching.
    run_updates(150, 1'b0);
    set_cfg(1, 0, 0, 0, 0, 0, 0);
    run_updates(150, 1'b0);
    set_cfg('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF);
    run_updates(150, 1'b0);
    rand_cfg(1'b0);
    run_updates(150, 1'b0);
    set_cfg(500, 100, 300, 1000, 800, 150, 300);
    run_updates(150, 1'b0);
    rand_cfg(1'b1);
    run_updates(150, 1'b0);
    // Now the offsets may latch; world headings are exercised afterwards.
    set_cfg(1000, 30, 200, 400, 600, 100, 200);
    run_updates(200, 1'b1);
    rand_cfg(1'b0);
    run_updates(175, 1'b1);
    set_cfg(10000, 10000, 0, 0, 0, 0, 0);
    run_updates(175, 1'b1);

    settle();
    repeat (20) @(posedge clk_i);
    if (faults == 0 && fused_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
